>>> rtl/ruas_pkg.sv
// Package: constants shared by the union area sweep unit.
`timescale 1ns / 1ps
`default_nettype none
package ruas_pkg;
    localparam int LEVELS      = 15;
    localparam int Y_CELLS     = 32768;
    localparam int NODE_W      = LEVELS + 1;
    localparam int NODES       = 2 * Y_CELLS;
    localparam int CNT_W       = 15;
    localparam int LEN_W       = 16;
    localparam int LVL_W       = 4;
    localparam int AREA_W      = 30;
    localparam logic [CNT_W-1:0] MAX_OVERLAP = 15'd16384;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam int ENTRY_W     = CNT_W + LEN_W;
endpackage
`default_nettype wire

>>> rtl/ruas_ram.sv
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ruas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/rectangle_union_area_sweep_unit.sv
// Top level: sweep line union area over a memory held segment tree.
//  channel | dir | tdata                                   | tuser
//  s_axis  | in  | edge_x[14:0] y_low[29:15] y_high[44:30]  | is_open
//  m_axis  | out | area_so_far[29:0]                       | order_error, underflow_error
// After reset a clearing pass writes all 65536 tree entries, one a cycle,
// before the first item is taken. Each entry holds a node's count and the
// covered length of its two children. Each node visit passes through a read state
// and a compute/write state; a partly covered node is visited three times, a fully
// covered or untouched node once, at most 117 visits per item. The result waits
// in an output register and holds off the input until taken.
`timescale 1ns / 1ps
`default_nettype none
module rectangle_union_area_sweep_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // edge_x, y_low, y_high, zero pad
    input  wire logic        s_axis_tuser,  // is_open
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // area_so_far, zero pad
    output logic [1:0]       m_axis_tuser   // order_error, underflow_error
);
    localparam int NW = ruas_pkg::NODE_W;
    localparam int LW = ruas_pkg::LVL_W;
    localparam int CW = ruas_pkg::CNT_W;
    localparam int EW = ruas_pkg::LEN_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_ROOT = 6'b000100,
        S_READ = 6'b001000, S_WORK = 6'b010000, S_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [NW-1:0] clr_reg;
    logic [14:0] px_reg;
    logic have_reg;
    logic [ruas_pkg::AREA_W-1:0] area_reg;
    logic [14:0] ylo_reg, yhi_reg;
    logic open_reg, oerr_reg, uerr_reg;
    // current node index; per level, whether children visited (0 none,1 left done,2 both)
    logic [NW-1:0] node_reg;
    logic [LW-1:0] lvl_reg;
    logic [1:0] phase_reg [ruas_pkg::LEVELS+1];
    logic [EW-1:0] llen_reg [ruas_pkg::LEVELS+1];
    logic [EW-1:0] rlen_reg [ruas_pkg::LEVELS+1];
    logic [EW-1:0] root_len;
    logic [15:0] dx;
    logic [31:0] prod;
    logic [32:0] sum;

    logic we;
    logic [NW-1:0] waddr, raddr;
    logic [ruas_pkg::ENTRY_W-1:0] wdata, rdata;
    ruas_ram #(.WIDTH(ruas_pkg::ENTRY_W), .DEPTH(ruas_pkg::NODES)) u_tree (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // node span in cells at level l: 2^(15-l); lo = (node - 2^l) << (15-l)
    logic [LW-1:0] shamt;
    logic [15:0] lo, hi, span;
    logic full, disj, leaf;
    logic [CW-1:0] ncnt;
    logic uf;
    logic [EW-1:0] nsub, nlen;
    logic [NW-1:0] base;
    always_comb
    begin
        shamt = LW'(ruas_pkg::LEVELS) - lvl_reg;
        base  = NW'(1) << lvl_reg;
        lo    = 16'((node_reg - base) << shamt);
        span  = 16'(1) << shamt;
        hi    = lo + span - 16'd1;
        full  = ({1'b0, ylo_reg} <= lo) && (hi < {1'b0, yhi_reg});
        disj  = (hi < {1'b0, ylo_reg}) || (lo >= {1'b0, yhi_reg});
        leaf  = (lvl_reg == LW'(ruas_pkg::LEVELS));
        ncnt  = rdata[ruas_pkg::ENTRY_W-1:EW];
        uf    = 1'b0;
        if (full)
        begin
            if (open_reg)
            begin
                if (ncnt < ruas_pkg::MAX_OVERLAP) ncnt = ncnt + CW'(1);
            end
            else if (ncnt == '0) uf = 1'b1;
            else ncnt = ncnt - CW'(1);
        end
        // children length: unchanged below a full or untouched node
        if (full || disj) nsub = rdata[EW-1:0];
        else nsub = llen_reg[lvl_reg] + rlen_reg[lvl_reg];
        // covered length of this node as seen by its parent
        if (ncnt != '0) nlen = span;
        else nlen = nsub;
    end

    always_comb
    begin
        dx   = {1'b0, s_axis_tdata[14:0]} - {1'b0, px_reg};
        prod = dx * root_len;
        sum  = 33'(area_reg) + 33'(prod);
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {2'b00, area_reg};
    assign m_axis_tuser  = {uerr_reg, oerr_reg};

    always_comb
    begin
        we = 1'b0;
        waddr = node_reg;
        wdata = {ncnt, nsub};
        raddr = node_reg;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                if (clr_reg == {NW{1'b1}}) state_next = S_IDLE;
            end
            S_IDLE:   if (s_axis_tvalid) state_next = S_ROOT;
            S_ROOT:   state_next = S_READ;
            S_READ:   state_next = S_WORK;
            S_WORK:
            begin
                if (!disj && (full || leaf || phase_reg[lvl_reg] == 2'd2))
                begin
                    we = 1'b1;
                end
                if ((disj || full || leaf || phase_reg[lvl_reg] == 2'd2)
                    && lvl_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_OUT:    if (m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // root covered length, read while waiting for an item
    assign root_len = (rdata[ruas_pkg::ENTRY_W-1:EW] != '0) ?
                      EW'(ruas_pkg::Y_CELLS) : rdata[EW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            px_reg <= '0;
            have_reg <= 1'b0;
            area_reg <= '0;
            node_reg <= NW'(1);
            lvl_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + NW'(1);
            if (state_reg == S_IDLE && s_axis_tvalid)
            begin
                ylo_reg  <= s_axis_tdata[29:15];
                yhi_reg  <= s_axis_tdata[44:30];
                open_reg <= s_axis_tuser;
                px_reg   <= (have_reg && (s_axis_tdata[14:0] < px_reg)) ?
                            px_reg : s_axis_tdata[14:0];
                node_reg <= NW'(1);
                lvl_reg  <= '0;
                phase_reg[0] <= 2'd0;
                llen_reg[0] <= '0;
                rlen_reg[0] <= '0;
                uerr_reg <= 1'b0;
                oerr_reg <= have_reg && (s_axis_tdata[14:0] < px_reg);
                if (have_reg && (s_axis_tdata[14:0] >= px_reg))
                begin
                    if (sum > 33'(ruas_pkg::AREA_MAX)) area_reg <= ruas_pkg::AREA_MAX;
                    else area_reg <= sum[ruas_pkg::AREA_W-1:0];
                end
                have_reg <= 1'b1;
            end
            if (state_reg == S_WORK)
            begin
                if (uf && !disj) uerr_reg <= 1'b1;
                if (disj || full || leaf || phase_reg[lvl_reg] == 2'd2)
                begin
                    // node done: report length to parent, pop
                    if (lvl_reg != '0)
                    begin
                        if (node_reg[0]) rlen_reg[lvl_reg - LW'(1)] <= nlen;
                        else llen_reg[lvl_reg - LW'(1)] <= nlen;
                        node_reg <= node_reg >> 1;
                        lvl_reg <= lvl_reg - LW'(1);
                    end
                end
                else
                begin
                    // descend into next child
                    phase_reg[lvl_reg] <= phase_reg[lvl_reg] + 2'd1;
                    node_reg <= {node_reg[NW-2:0], phase_reg[lvl_reg][0]};
                    lvl_reg <= lvl_reg + LW'(1);
                    phase_reg[lvl_reg + LW'(1)] <= 2'd0;
                end
            end
        end
    end
endmodule
`default_nettype wire
